/* hw/rtl/lzwhd_pkg.sv */
// Shared types and constants for the hashed LZW dictionary.
package lzwhd_pkg;

	localparam int PREFIX_W   = 13;
	localparam int SUFFIX_W   = 8;
	localparam int CODE_W     = 12;
	localparam int NEXT_W     = 13;
	localparam int FIRST_FREE = 258;
	localparam logic [31:0] GOLDEN = 32'h9E3779B1;
	localparam logic [PREFIX_W-1:0] EMPTY_PREFIX = '1;

	typedef enum logic [1:0] {
		KIND_LOOKUP,
		KIND_RESET,
		KIND_DROP
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [PREFIX_W-1:0]   prefix;
		logic [SUFFIX_W-1:0]   suffix;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} eng_ctl_t;

	typedef struct packed {
		logic              found;
		logic              added;
		logic [CODE_W-1:0] code;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_BYTES,
		ST_IDLE,
		ST_HASH,
		ST_SEED,
		ST_SLOT_RD,
		ST_SLOT_CHK,
		ST_ENT_CHK,
		ST_EMIT
	} state_t;

endpackage

/* hw/rtl/lzwhd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lzwhd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/lzwhd_front.sv */
// Front end: accepts items, classifies them and queues them for the engine.
module lzwhd_front
	import lzwhd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	input  eng_ctl_t    ctl,
	output qhead_t      head
);

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	always_comb begin
		cls.prefix = s_tdata[12:0];
		cls.suffix = s_tdata[20:13];
		if (s_tuser) begin
			cls.kind = KIND_RESET;
		end else if (cls.prefix[PREFIX_W-1] && cls.prefix != EMPTY_PREFIX) begin
			cls.kind = KIND_DROP;
		end else begin
			cls.kind = KIND_LOOKUP;
		end
	end

	assign s_tready   = (cnt_q != 2'd2) && !ctl.busy;
	assign push       = s_tvalid && s_tready;
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (ctl.pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(ctl.pop);
		end
	end

endmodule

/* hw/rtl/lzwhd_engine.sv */
// Back end: clears and preloads the table, probes, inserts and drives results.
module lzwhd_engine
	import lzwhd_pkg::*;
#(
	parameter int CODE_COUNT = 4096,
	parameter int HASH_SLOTS = 8192,
	parameter int HASH_BITS  = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  qhead_t      head,
	output eng_ctl_t    ctl,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata
);

	localparam int CW   = $clog2(CODE_COUNT);
	localparam int NW   = CW + 1;
	localparam int CMPW = (NW > PREFIX_W) ? NW : PREFIX_W;
	localparam logic [HASH_BITS-1:0] HMAX = '1;

	state_t state_q, state_d;

	logic [HASH_BITS-1:0] clr_q, idx_q, n_q;
	logic [7:0]           byte_q;
	logic                 bytes_q, reply_q;
	logic [NW-1:0]        next_q;
	logic [PREFIX_W-1:0]  pfx_q;
	logic [SUFFIX_W-1:0]  sfx_q;
	logic [31:0]          mul_s1;
	logic [CW-1:0]        code_q;
	result_t              res_q;
	logic                 m_valid_q;
	logic [31:0]          m_data_q;

	logic                 slot_we;
	logic [HASH_BITS-1:0] slot_waddr;
	logic [CW:0]          slot_wdata, slot_rdata;
	logic                 ent_we;
	logic [CW+7:0]        ent_rdata;
	logic                 slot_v;
	logic [CW-1:0]        slot_c;
	logic                 hit, miss, step, free_c, ins, finish, ent_match, byte_match;
	logic                 pfx_lt, room;
	logic [CW-1:0]        hit_code;

	assign slot_v = slot_rdata[CW];
	assign slot_c = slot_rdata[CW-1:0];

	lzwhd_ram #(.WIDTH(CW + 1), .DEPTH(HASH_SLOTS)) u_slots (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (idx_q),
		.rdata (slot_rdata)
	);

	lzwhd_ram #(.WIDTH(CW + 8), .DEPTH(CODE_COUNT)) u_entries (
		.clk   (clk),
		.we    (ent_we),
		.waddr (next_q[CW-1:0]),
		.wdata ({CW'(pfx_q), sfx_q}),
		.raddr (slot_c),
		.rdata (ent_rdata)
	);

	assign byte_match = (pfx_q == EMPTY_PREFIX) && (sfx_q == slot_c[7:0]);
	assign ent_match  = !pfx_q[PREFIX_W-1] && (CMPW'(pfx_q) == CMPW'(ent_rdata[CW+7:8]))
		&& (sfx_q == ent_rdata[7:0]);
	assign pfx_lt     = CMPW'(pfx_q) < CMPW'(next_q);
	assign room       = next_q < NW'(CODE_COUNT);
	assign hit_code   = (state_q == ST_SLOT_CHK) ? slot_c : code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ctl.pop    = 1'b0;
		ctl.busy   = (state_q == ST_CLEAR) || (state_q == ST_BYTES) || bytes_q;
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wdata = '0;
		ent_we     = 1'b0;
		hit        = 1'b0;
		step       = 1'b0;
		free_c     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				if (clr_q == HMAX) begin
					state_d = ST_BYTES;
				end
			end
			ST_BYTES: state_d = ST_HASH;
			ST_IDLE: begin
				if (head.valid) begin
					ctl.pop = 1'b1;
					case (head.item.kind)
						KIND_RESET: state_d = ST_CLEAR;
						KIND_DROP:  state_d = ST_EMIT;
						default:    state_d = ST_HASH;
					endcase
				end
			end
			ST_HASH:    state_d = ST_SEED;
			ST_SEED:    state_d = ST_SLOT_RD;
			ST_SLOT_RD: state_d = ST_SLOT_CHK;
			ST_SLOT_CHK: begin
				if (!slot_v) begin
					free_c = 1'b1;
				end else if (|slot_c[CW-1:8]) begin
					state_d = ST_ENT_CHK;
				end else if (byte_match) begin
					hit = 1'b1;
				end else begin
					step = 1'b1;
				end
			end
			ST_ENT_CHK: begin
				if (ent_match) begin
					hit = 1'b1;
				end else begin
					step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (!m_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		miss = free_c || (step && n_q == HMAX);
		if (step && n_q != HMAX) begin
			state_d = ST_SLOT_RD;
		end
		ins    = miss && !bytes_q && free_c && !pfx_q[PREFIX_W-1] && pfx_lt && room;
		finish = hit || miss;
		if (miss && bytes_q && free_c) begin
			slot_we    = 1'b1;
			slot_wdata = {1'b1, CW'(byte_q)};
		end
		if (ins) begin
			slot_we    = 1'b1;
			slot_wdata = {1'b1, next_q[CW-1:0]};
			ent_we     = 1'b1;
		end
		if (finish) begin
			if (!bytes_q) begin
				state_d = ST_EMIT;
			end else if (byte_q == 8'hFF) begin
				state_d = reply_q ? ST_EMIT : ST_IDLE;
			end else begin
				state_d = ST_BYTES;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			byte_q    <= '0;
			bytes_q   <= 1'b0;
			reply_q   <= 1'b0;
			next_q    <= NW'(FIRST_FREE);
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == HMAX) begin
					byte_q  <= '0;
					bytes_q <= 1'b1;
				end
			end
			if (ctl.pop && head.item.kind == KIND_RESET) begin
				clr_q   <= '0;
				reply_q <= 1'b1;
			end
			if (ins) begin
				next_q <= next_q + 1'b1;
			end
			if (finish && bytes_q) begin
				if (byte_q == 8'hFF) begin
					bytes_q <= 1'b0;
					next_q  <= NW'(FIRST_FREE);
				end else begin
					byte_q <= byte_q + 1'b1;
				end
			end
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (state_q == ST_EMIT && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
				reply_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BYTES) begin
			pfx_q <= EMPTY_PREFIX;
			sfx_q <= byte_q;
		end
		if (ctl.pop) begin
			pfx_q <= head.item.prefix;
			sfx_q <= head.item.suffix;
			res_q <= '0;
		end
		if (state_q == ST_HASH) begin
			mul_s1 <= {11'd0, pfx_q, sfx_q} * GOLDEN;
		end
		if (state_q == ST_SEED) begin
			idx_q <= mul_s1[31 -: HASH_BITS];
			n_q   <= '0;
		end
		if (state_q == ST_SLOT_CHK) begin
			code_q <= slot_c;
		end
		if (step) begin
			idx_q <= idx_q - 1'b1;
			n_q   <= n_q + 1'b1;
		end
		if (hit && !bytes_q) begin
			res_q.found <= 1'b1;
			res_q.code  <= CODE_W'(hit_code);
		end
		if (ins) begin
			res_q.added <= 1'b1;
			res_q.code  <= CODE_W'(next_q);
		end
		if (finish && bytes_q && byte_q == 8'hFF) begin
			res_q <= '0;
		end
		if (state_q == ST_EMIT && (!m_valid_q || m_tready)) begin
			m_data_q <= {5'd0, NEXT_W'(next_q), res_q.code, res_q.added, res_q.found};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

/* hw/rtl/lzw_hashed_dictionary.sv */
// Each lookup item is hashed and probed slot by slot in the slot RAM (a longer string also
// reads the entry RAM), then its result is emitted; the engine works on one item at a time,
// while the front end queues up to two more.
// A reset item or arst_n clears HASH_SLOTS slots one per cycle, then places the
// 256 byte codes; no item is accepted meanwhile.
// arst_n is asynchronous, active low; the clearing pass starts right after it.
module lzw_hashed_dictionary
	import lzwhd_pkg::*;
#(
	parameter int CODE_COUNT = 4096,
	parameter int HASH_SLOTS = 8192,
	parameter int HASH_BITS  = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // prefix[12:0], suffix[20:13], zero pad
	input  logic        s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // found[0], added[1], code[13:2], next_code[26:14], zero pad
);

	qhead_t   head;
	eng_ctl_t ctl;

	lzwhd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.ctl      (ctl),
		.head     (head)
	);

	lzwhd_engine #(
		.CODE_COUNT (CODE_COUNT),
		.HASH_SLOTS (HASH_SLOTS),
		.HASH_BITS  (HASH_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.ctl      (ctl),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* hw/rtl/lzwhd_checker.sv */
// Port-level checks for the hashed LZW dictionary, bound to the top level.
module lzwhd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("found and added both set");

	a_added: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> ({1'b0, m_tdata[13:2]} + 13'd1) == m_tdata[26:14])
		else $error("added code does not precede next code");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] && !m_tdata[1] |-> m_tdata[13:2] == 12'd0)
		else $error("nonzero code without hit or insert");

endmodule

bind lzw_hashed_dictionary lzwhd_checker u_chk (.*);
